/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the page table walker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising edge of clk, suspended while rst_n is low.
`define PTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on every rising edge of clk, reset included.
`define PTW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ptw_pkg.sv */
// ---------------------------------------------------------------------------
// ptw_pkg
// Sizes, codes, types and helper functions of the radix page table walker.
// ---------------------------------------------------------------------------
package ptw_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int LEVELS     = 5;
    localparam int INDEX_BITS = 9;

    localparam int VPN_W   = 45;
    localparam int PPN_W   = 52;
    localparam int CFG_W   = 4;
    localparam int ENTRY_W = PPN_W + 1;

    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int NEXT_W      = $clog2(NUM_FRAMES + 1);
    localparam int ADDR_W      = FRAME_W + INDEX_BITS;
    localparam int STORE_DEPTH = NUM_FRAMES * (2 ** INDEX_BITS);
    localparam int WALK_W      = LEVELS * INDEX_BITS;
    localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMAP   = 2'd1,
        ST_NOFRAME = 2'd2
    } status_t;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
    } alloc_rsp_t;

    // Root frame register taken modulo the number of frames.
    function automatic logic [FRAME_W-1:0] root_wrap(logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] v;
        v = r;
        for (int i = 0; i < 8; i++) begin
            if (int'(v) >= NUM_FRAMES) begin
                v = v - CFG_W'(NUM_FRAMES);
            end
        end
        return FRAME_W'(v);
    endfunction

    // Places the page number so that the level 0 index is the top slice.
    function automatic logic [WALK_W-1:0] fit_vpn(logic [VPN_W-1:0] v);
        logic [WALK_W-1:0] r;
        r = '0;
        for (int i = 0; i < WALK_W; i++) begin
            if (i < VPN_W) begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

endpackage

/* src/ptw_ram.sv */
// ---------------------------------------------------------------------------
// ptw_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ptw_alloc.sv */
// ---------------------------------------------------------------------------
// ptw_alloc
// Increasing frame allocator that passes over the root frame.
// ---------------------------------------------------------------------------
module ptw_alloc
    import ptw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [FRAME_W-1:0] root,
    output alloc_rsp_t         rsp
);

    logic [NEXT_W-1:0] next_reg, next_next;
    logic [NEXT_W-1:0] cand;
    logic              skip;

    always_comb
    begin
        skip = (next_reg < NEXT_W'(NUM_FRAMES)) && (next_reg == NEXT_W'(root));
        cand = skip ? NEXT_W'(next_reg + 1'b1) : next_reg;
        rsp.ok    = cand < NEXT_W'(NUM_FRAMES);
        rsp.frame = cand[FRAME_W-1:0];
        // A failed allocation still keeps the skip over the root.
        next_next = next_reg;
        if (take) begin
            next_next = rsp.ok ? NEXT_W'(cand + 1'b1) : cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            next_reg <= '0;
        end else begin
            next_reg <= next_next;
        end
    end

endmodule

/* src/ptw_walk.sv */
// ---------------------------------------------------------------------------
// ptw_walk
// Sequencer that clears the table store and walks it one level at a time.
// ---------------------------------------------------------------------------
module ptw_walk
    import ptw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               opcode,
    input  logic [VPN_W-1:0]   vpn,
    input  logic [PPN_W-1:0]   ppn,
    input  logic               unmap,
    input  logic [FRAME_W-1:0] root,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [PPN_W-1:0]   result_ppn,
    output logic               ram_en,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_addr,
    output logic [ENTRY_W-1:0] ram_wdata,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output logic               alloc_take,
    input  alloc_rsp_t         alloc_rsp
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVELS - 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               done_reg, done_next;
    logic               op_reg, op_next;
    logic               unmap_reg, unmap_next;
    logic [PPN_W-1:0]   ppn_reg, ppn_next;
    logic [WALK_W-1:0]  vpn_reg, vpn_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    status_t            status_reg, status_next;
    logic [PPN_W-1:0]   rppn_reg, rppn_next;

    logic               ent_valid;
    logic [PPN_W-1:0]   ent_num;
    logic               num_ok;
    logic               fin, adv;
    status_t            fin_st;
    logic [FRAME_W-1:0] adv_frame;

    assign ent_valid = ram_rdata[0];
    assign ent_num   = ram_rdata[ENTRY_W-1:1];
    assign num_ok    = ent_num < PPN_W'(NUM_FRAMES);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        level_next  = level_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        unmap_next  = unmap_reg;
        ppn_next    = ppn_reg;
        vpn_next    = vpn_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        rppn_next   = rppn_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = {frame_reg, vpn_reg[WALK_W-1 -: INDEX_BITS]};
        ram_wdata   = '0;
        alloc_take  = 1'b0;
        fin         = 1'b0;
        fin_st      = ST_OK;
        adv         = 1'b0;
        adv_frame   = ent_num[FRAME_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    op_next    = opcode;
                    unmap_next = unmap;
                    ppn_next   = ppn;
                    vpn_next   = fit_vpn(vpn);
                    frame_next = root;
                    level_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                ram_en     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (level_reg != LAST_LVL) begin
                    if (op_reg == OP_QUERY) begin
                        if (!ent_valid || !num_ok) begin
                            fin    = 1'b1;
                            fin_st = ST_NOMAP;
                        end else begin
                            adv = 1'b1;
                        end
                    end else if (!ent_valid) begin
                        // Missing interior table: link in a fresh frame.
                        alloc_take = 1'b1;
                        if (alloc_rsp.ok) begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = {PPN_W'(alloc_rsp.frame), 1'b1};
                            adv       = 1'b1;
                            adv_frame = alloc_rsp.frame;
                        end else begin
                            fin    = 1'b1;
                            fin_st = ST_NOFRAME;
                        end
                    end else if (!num_ok) begin
                        fin    = 1'b1;
                        fin_st = ST_NOFRAME;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    fin = 1'b1;
                    if (op_reg == OP_QUERY) begin
                        if (!ent_valid) begin
                            fin_st = ST_NOMAP;
                        end else begin
                            rppn_next = ent_num;
                        end
                    end else begin
                        // Unmap keeps the page number and drops the valid bit.
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = unmap_reg ? {ent_num, 1'b0} : {ppn_reg, 1'b1};
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE && start) begin
            rppn_next = '0;
        end
        if (fin) begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = fin_st;
        end
        if (adv) begin
            frame_next = adv_frame;
            vpn_next   = vpn_reg << INDEX_BITS;
            level_next = LVL_W'(level_reg + 1'b1);
            state_next = S_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        unmap_reg  <= unmap_next;
        ppn_reg    <= ppn_next;
        vpn_reg    <= vpn_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
        rppn_reg   <= rppn_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign result_ppn = rppn_reg;

endmodule

/* src/radix_page_table_walker_top.sv */
// ---------------------------------------------------------------------------
// radix_page_table_walker_top
// Five-level radix page table walker over a local store of table frames.
// ---------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  config    cfg_wr_en, cfg_wr_data (root frame)      written when cfg_wr_en
//  request   start, opcode, vpn, ppn, unmap           taken when start && !busy
//  result    done, status, result_ppn                 valid while done is high
//
//  A request takes a store read, then an evaluate and write back, for each
//  table level; done comes after the last level, or earlier when the walk
//  stops at a missing entry or finds no free frame. busy is low in the done
//  cycle, so the next request can be taken then. After reset the store is
//  cleared one entry a cycle with busy high; the root frame register can be
//  written meanwhile. Results cannot be stalled.
// ---------------------------------------------------------------------------
module radix_page_table_walker_top
    import ptw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [VPN_W-1:0] vpn,
    input  logic [PPN_W-1:0] ppn,
    input  logic             unmap,
    output logic             done,
    output logic [1:0]       status,
    output logic [PPN_W-1:0] result_ppn
);

    logic [CFG_W-1:0]   root_frame_reg;
    logic [FRAME_W-1:0] root_eff;

    logic               ram_en;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               alloc_take;
    alloc_rsp_t         alloc_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            root_frame_reg <= '0;
        end else if (cfg_wr_en) begin
            root_frame_reg <= cfg_wr_data;
        end
    end

    assign root_eff = root_wrap(root_frame_reg);

    ptw_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .vpn        (vpn),
        .ppn        (ppn),
        .unmap      (unmap),
        .root       (root_eff),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .result_ppn (result_ppn),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .alloc_take (alloc_take),
        .alloc_rsp  (alloc_rsp)
    );

    ptw_alloc u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (alloc_take),
        .root  (root_eff),
        .rsp   (alloc_rsp)
    );

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

/* src/ptw_checker.sv */
// ---------------------------------------------------------------------------
// ptw_checker
// Port-level checks of the page table walker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_checker
    import ptw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [1:0]       status,
    input logic [PPN_W-1:0] result_ppn
);

    // A result only closes a walk that was in progress.
    `PTW_ASSERT(a_done_after_busy, done |-> $past(busy), "done without a walk in progress")

    // A taken request makes the block busy, with no result, in the next cycle.
    `PTW_ASSERT(a_busy_after_take, (start && !busy) |=> (busy && !done), "request not held busy")

    `PTW_ASSERT(a_status_code, done |-> (status <= ST_NOFRAME), "undefined status code")

    // Only a successful lookup carries a page number.
    `PTW_ASSERT(a_ppn_zero, (done && status != ST_OK) |-> (result_ppn == '0), "stray page number")

    // A cycle spent in reset leaves the result strobe low on the next edge.
    `PTW_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !done, "result strobe during reset")

endmodule

bind radix_page_table_walker_top ptw_checker u_ptw_checker (.*);
